// ===== rtl/hmpe_pkg.sv =====
// Shared types, codes and constants of the haptic motor pattern engine.
package hmpe_pkg;

	// Request queue and command buffer sizes
	localparam int QUEUE_DEPTH = 3;
	localparam int QUEUE_LAST  = QUEUE_DEPTH - 1;
	localparam int FIFO_DEPTH  = 2;
	localparam int FIFO_PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	// Frame counter remainder unit: two quotient bits per cycle
	localparam int FRAME_W   = 32;
	localparam int MOD_STEPS = FRAME_W / 2;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS);

	// Command codes of the input beat
	localparam logic [2:0] CMD_TICK        = 3'd0;
	localparam logic [2:0] CMD_QUEUE       = 3'd1;
	localparam logic [2:0] CMD_DECAY       = 3'd2;
	localparam logic [2:0] CMD_PULSE       = 3'd3;
	localparam logic [2:0] CMD_PULSE_STR   = 3'd4;
	localparam logic [2:0] CMD_PULSE_SHORT = 3'd5;
	localparam logic [2:0] CMD_CANCEL      = 3'd6;

	// Drive pattern constants
	localparam logic [15:0] ACC_FIRE       = 16'h0100;
	localparam logic [15:0] ACC_BIAS       = 16'd4;
	localparam int          CUBE_SHIFT     = 9;
	localparam logic [2:0]  LEAD_FRAMES    = 3'd4;
	localparam logic [2:0]  PULSE_ARM      = 3'd7;
	localparam logic [2:0]  PULSE_MIN      = 3'd4;
	localparam logic [2:0]  PULSE_SOLID    = 3'd5;
	localparam logic [2:0]  PULSE_GATE_MIN = 3'd2;
	localparam logic [2:0]  PERIOD_PLAIN   = 3'd7;
	localparam logic [2:0]  PERIOD_SHORT   = 3'd4;
	localparam logic [2:0]  PERIOD_BASE    = 3'd5;
	localparam logic [2:0]  STRENGTH_MAX   = 3'd4;
	localparam logic [4:0]  ERR_MAX        = 5'd31;
	localparam logic [15:0] IDLE_LIMIT     = 16'd4;

	// Configuration register reset values
	localparam logic [4:0] ERROR_LIMIT_RST     = 5'd30;
	localparam logic [7:0] PROBE_INTERVAL_RST  = 8'd60;
	localparam logic [7:0] SOLID_THRESHOLD_RST = 8'd70;

	typedef enum logic [1:0] {
		REG_ERROR_LIMIT,
		REG_PROBE_INTERVAL,
		REG_SOLID_THRESHOLD
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_EMPTY,
		KIND_SOLID,
		KIND_DENSITY
	} kind_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_TICK,
		OP_QUEUE,
		OP_DECAY,
		OP_ARM,
		OP_SHORT,
		OP_CANCEL
	} op_t;

	typedef enum logic {
		B_IDLE,
		B_TICK
	} back_state_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [14:0] duration;
		logic [7:0]  level;
		logic [7:0]  decay;
		logic [2:0]  strength;
		logic        demo_active;
		logic        reset_active;
		logic [31:0] frame_count;
		logic        motor_ok;
		logic        init_ok;
	} req_t;

	typedef struct packed {
		logic motor_cmd_valid;
		logic motor_on;
		logic probe_issued;
		logic pak_present;
		logic idle;
	} rsp_t;

	typedef struct packed {
		logic [4:0] error_limit;
		logic [7:0] probe_interval;
		logic [7:0] solid_threshold;
	} cfg_t;

	// Classified command as it travels from front to back
	typedef struct packed {
		op_t         op;
		kind_t       kind;
		logic [7:0]  level;
		logic [14:0] duration;
		logic [7:0]  decay;
		logic        period_wr;
		logic [2:0]  period;
		logic        rst;
		logic [31:0] frame;
		logic        ok;
		logic        init;
	} item_t;

	// Remainder unit status
	typedef struct packed {
		logic done;
		logic pulse_hit;
		logic probe_hit;
	} mod_res_t;

endpackage

// ===== rtl/haptic_motor_pattern_engine.sv =====
// Top level: configuration registers, command decode, command queue and back end.
// A command passes the queue and then the result register; a tick also waits in B_TICK
// for the 2-bit-per-cycle frame remainder unit, which holds the back end until done.
// Other commands go one per cycle while the result is not stalled. A 2-entry queue
// decouples input from execution.
// Reset (arst_n low, asynchronous): slots empty, pattern idle, pak absent, registers
// at defaults; no clearing pass, items are accepted from the first cycle after reset.
module haptic_motor_pattern_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  hmpe_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output hmpe_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [7:0]     cfg_data
);
	import hmpe_pkg::*;

	cfg_t  cfg_q;
	item_t front_item;
	item_t head;
	logic  head_valid;
	logic  pop;
	logic  full;

	assign cfg_ready = 1'b1;
	assign req_stall = full;

	// Write configuration registers; other indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.error_limit     <= ERROR_LIMIT_RST;
			cfg_q.probe_interval  <= PROBE_INTERVAL_RST;
			cfg_q.solid_threshold <= SOLID_THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ERROR_LIMIT:     cfg_q.error_limit     <= cfg_data[4:0];
				REG_PROBE_INTERVAL:  cfg_q.probe_interval  <= cfg_data;
				REG_SOLID_THRESHOLD: cfg_q.solid_threshold <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	hmpe_front u_front (
		.req             (req),
		.solid_threshold (cfg_q.solid_threshold),
		.item            (front_item)
	);

	hmpe_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (req_valid && !full),
		.push_item  (front_item),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	hmpe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.cfg        (cfg_q),
		.rsp_stall  (rsp_stall),
		.rsp_valid  (rsp_valid),
		.rsp        (rsp)
	);

endmodule

// ===== rtl/hmpe_front.sv =====
// Front end: decodes an input beat into a classified command.
module hmpe_front (
	input  hmpe_pkg::req_t  req,
	input  logic [7:0]      solid_threshold,
	output hmpe_pkg::item_t item
);
	import hmpe_pkg::*;

	// Classify the command; drop gated commands during demo playback
	always_comb begin
		item.op        = OP_NOP;
		item.kind      = (req.level > solid_threshold) ? KIND_SOLID : KIND_DENSITY;
		item.level     = req.level;
		item.duration  = req.duration;
		item.decay     = req.decay;
		item.period_wr = 1'b0;
		item.period    = PERIOD_PLAIN;
		item.rst       = req.reset_active;
		item.frame     = req.frame_count;
		item.ok        = req.motor_ok;
		item.init      = req.init_ok;
		case (req.cmd)
			CMD_TICK: begin
				item.op = OP_TICK;
			end
			CMD_QUEUE: begin
				if (!req.demo_active)
					item.op = OP_QUEUE;
			end
			CMD_DECAY: begin
				item.op = OP_DECAY;
			end
			CMD_PULSE: begin
				if (!req.demo_active) begin
					item.op        = OP_ARM;
					item.period_wr = 1'b1;
					item.period    = PERIOD_PLAIN;
				end
			end
			CMD_PULSE_STR: begin
				if (!req.demo_active) begin
					item.op        = OP_ARM;
					item.period_wr = (req.strength <= STRENGTH_MAX);
					item.period    = PERIOD_BASE - req.strength;
				end
			end
			CMD_PULSE_SHORT: begin
				if (!req.demo_active)
					item.op = OP_SHORT;
			end
			CMD_CANCEL: begin
				item.op = OP_CANCEL;
			end
			default: begin
				item.op = OP_NOP;
			end
		endcase
	end

endmodule

// ===== rtl/hmpe_fifo.sv =====
// Short command queue between front and back end.
module hmpe_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hmpe_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output hmpe_pkg::item_t head
);
	import hmpe_pkg::*;

	item_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
		if (p == FIFO_PTR_W'(FIFO_DEPTH - 1))
			return '0;
		return p + 1'b1;
	endfunction

	assign full       = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Store the beat
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== rtl/hmpe_mod_unit.sv =====
// Serial remainder of the frame counter by pulse period and probe interval.
module hmpe_mod_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [31:0]         frame,
	input  logic [7:0]          div_a,
	input  logic [7:0]          div_b,
	output hmpe_pkg::mod_res_t  res
);
	import hmpe_pkg::*;

	logic                 busy_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [31:0]          shift_q;
	logic [7:0]           da_q;
	logic [7:0]           db_q;
	logic [7:0]           ra_q;
	logic [7:0]           rb_q;

	// One restoring step: bring in a bit, subtract the divisor if it fits
	function automatic logic [7:0] rem_step(input logic [7:0] r, input logic b,
			input logic [7:0] d);
		logic [8:0] t;
		t = {r, b};
		if (t >= {1'b0, d})
			t = t - {1'b0, d};
		return t[7:0];
	endfunction

	assign res.done      = !busy_q;
	assign res.pulse_hit = (ra_q == '0);
	assign res.probe_hit = (rb_q == '0);

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == MOD_CNT_W'(MOD_STEPS - 1))
				busy_q <= 1'b0;
		end
	end

	// Shift two dividend bits into both remainders per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= frame;
			da_q    <= div_a;
			db_q    <= div_b;
			ra_q    <= '0;
			rb_q    <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[29:0], 2'b00};
			ra_q    <= rem_step(rem_step(ra_q, shift_q[31], da_q), shift_q[30], da_q);
			rb_q    <= rem_step(rem_step(rb_q, shift_q[31], db_q), shift_q[30], db_q);
		end
	end

endmodule

// ===== rtl/hmpe_back.sv =====
// Back end: request slots, active pattern, pak tracking and result register.
module hmpe_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  hmpe_pkg::item_t head,
	output logic            pop,
	input  hmpe_pkg::cfg_t  cfg,
	input  logic            rsp_stall,
	output logic            rsp_valid,
	output hmpe_pkg::rsp_t  rsp
);
	import hmpe_pkg::*;

	back_state_t state_q, state_d;

	// Request slots
	kind_t       slot_kind_q  [QUEUE_DEPTH];
	logic [7:0]  slot_level_q [QUEUE_DEPTH];
	logic [14:0] slot_dur_q   [QUEUE_DEPTH];
	logic [7:0]  slot_decay_q [QUEUE_DEPTH];
	kind_t       nx_kind      [QUEUE_DEPTH];
	logic [7:0]  nx_slot_lvl  [QUEUE_DEPTH];
	logic [14:0] nx_slot_dur  [QUEUE_DEPTH];
	logic [7:0]  nx_slot_dec  [QUEUE_DEPTH];

	// Active pattern and pak state
	kind_t       mode_q, nx_mode;
	logic [7:0]  level_q, nx_level;
	logic [14:0] remain_q, nx_remain;
	logic [7:0]  decay_q, nx_decay;
	logic [2:0]  lead_q, nx_lead;
	logic [15:0] acc_q, nx_acc;
	logic [2:0]  pcount_q, nx_pcount;
	logic [2:0]  period_q, nx_period;
	logic        pak_q, nx_pak;
	logic [4:0]  err_q, nx_err;

	item_t       tick_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q, rsp_d;
	logic        load_rsp;
	logic        out_free;
	logic        mod_start;
	mod_res_t    mod_res;
	logic        drv_on;
	logic        empty;

	// Level cube pipeline
	logic [7:0]  lvl_s1;
	logic [7:0]  lvl_s2;
	logic [15:0] sq_s2;
	logic [23:0] cube_s3;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	hmpe_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.frame  (head.frame),
		.div_a  ({5'd0, period_q}),
		.div_b  (cfg.probe_interval),
		.res    (mod_res)
	);

	// Decay the level, then square and cube it
	always_ff @(posedge clk) begin
		lvl_s1  <= (level_q > decay_q) ? level_q - decay_q : 8'd0;
		lvl_s2  <= lvl_s1;
		sq_s2   <= {8'd0, lvl_s1} * {8'd0, lvl_s1};
		cube_s3 <= {8'd0, sq_s2} * {16'd0, lvl_s2};
	end

	// Next state, slot updates and result
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		mod_start = 1'b0;
		load_rsp  = 1'b0;
		rsp_d     = '0;
		drv_on    = 1'b0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			nx_kind[i]     = slot_kind_q[i];
			nx_slot_lvl[i] = slot_level_q[i];
			nx_slot_dur[i] = slot_dur_q[i];
			nx_slot_dec[i] = slot_decay_q[i];
		end
		nx_mode   = mode_q;
		nx_level  = level_q;
		nx_remain = remain_q;
		nx_decay  = decay_q;
		nx_lead   = lead_q;
		nx_acc    = acc_q;
		nx_pcount = pcount_q;
		nx_period = period_q;
		nx_pak    = pak_q;
		nx_err    = err_q;

		case (state_q)
			B_IDLE: begin
				if (head_valid && head.op == OP_TICK) begin
					// Load slot 0 into the active pattern and shift the slots
					pop       = 1'b1;
					mod_start = 1'b1;
					state_d   = B_TICK;
					if (slot_kind_q[0] != KIND_EMPTY) begin
						nx_acc    = '0;
						nx_lead   = LEAD_FRAMES;
						nx_mode   = slot_kind_q[0];
						nx_remain = slot_dur_q[0];
						nx_level  = slot_level_q[0];
						nx_decay  = slot_decay_q[0];
					end
					for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
						nx_kind[i]     = slot_kind_q[i+1];
						nx_slot_lvl[i] = slot_level_q[i+1];
						nx_slot_dur[i] = slot_dur_q[i+1];
						nx_slot_dec[i] = slot_decay_q[i+1];
					end
					nx_kind[QUEUE_LAST] = KIND_EMPTY;
				end else if (head_valid && out_free) begin
					pop      = 1'b1;
					load_rsp = 1'b1;
					case (head.op)
						OP_QUEUE: begin
							nx_kind[QUEUE_LAST]     = head.kind;
							nx_slot_lvl[QUEUE_LAST] = head.level;
							nx_slot_dur[QUEUE_LAST] = head.duration;
							nx_slot_dec[QUEUE_LAST] = '0;
						end
						OP_DECAY: begin
							nx_slot_dec[QUEUE_LAST] = head.decay;
						end
						OP_ARM: begin
							if (pcount_q == '0)
								nx_pcount = PULSE_ARM;
							else if (pcount_q < PULSE_MIN)
								nx_pcount = PULSE_MIN;
							if (head.period_wr)
								nx_period = head.period;
						end
						OP_SHORT: begin
							nx_pcount = PULSE_MIN;
							nx_period = PERIOD_SHORT;
						end
						OP_CANCEL: begin
							// Probe, stop the motor if found, flush the slots, remaining duration and pulse count
							rsp_d.probe_issued    = 1'b1;
							rsp_d.motor_cmd_valid = head.init;
							nx_pak                = head.init;
							for (int i = 0; i < QUEUE_DEPTH; i++)
								nx_kind[i] = KIND_EMPTY;
							nx_remain = '0;
							nx_pcount = '0;
						end
						default: begin
						end
					endcase
				end
			end
			B_TICK: begin
				if (mod_res.done && out_free) begin
					load_rsp = 1'b1;
					state_d  = B_IDLE;
					if (!tick_q.rst) begin
						if (lead_q != '0) begin
							nx_lead = lead_q - 1'b1;
							drv_on  = 1'b1;
						end else if (remain_q != '0) begin
							nx_remain = remain_q - 1'b1;
							nx_level  = lvl_s1;
							if (mode_q == KIND_SOLID) begin
								drv_on = 1'b1;
							end else if (acc_q >= ACC_FIRE) begin
								nx_acc = acc_q - ACC_FIRE;
								drv_on = 1'b1;
							end else begin
								nx_acc = acc_q + 16'(cube_s3 >> CUBE_SHIFT) + ACC_BIAS;
							end
						end else if (pcount_q >= PULSE_SOLID) begin
							drv_on = 1'b1;
						end else if (pcount_q >= PULSE_GATE_MIN && period_q != '0 &&
								mod_res.pulse_hit) begin
							drv_on = 1'b1;
						end
						if (pcount_q != '0)
							nx_pcount = pcount_q - 1'b1;
					end
					// Issue the command and track failures, or probe for an absent pak on a probe-interval hit
					if (pak_q) begin
						rsp_d.motor_cmd_valid = 1'b1;
						rsp_d.motor_on        = drv_on;
						if (tick_q.ok)
							nx_err = '0;
						else if (err_q < ERR_MAX)
							nx_err = err_q + 1'b1;
						if (nx_err >= cfg.error_limit)
							nx_pak = 1'b0;
					end else if (cfg.probe_interval != '0 && mod_res.probe_hit) begin
						rsp_d.probe_issued = 1'b1;
						nx_pak             = tick_q.init;
						nx_err             = '0;
					end
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase

		empty = 1'b1;
		for (int i = 0; i < QUEUE_DEPTH; i++)
			if (nx_kind[i] != KIND_EMPTY)
				empty = 1'b0;
		rsp_d.pak_present = nx_pak;
		rsp_d.idle        = (({13'd0, nx_lead} + {1'b0, nx_remain}) < IDLE_LIMIT) && empty;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= B_IDLE;
		else
			state_q <= state_d;
	end

	// Pattern, pak and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_DEPTH; i++)
				slot_kind_q[i] <= KIND_EMPTY;
			mode_q      <= KIND_EMPTY;
			level_q     <= '0;
			remain_q    <= '0;
			decay_q     <= '0;
			lead_q      <= '0;
			acc_q       <= '0;
			pcount_q    <= '0;
			period_q    <= '0;
			pak_q       <= 1'b0;
			err_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			for (int i = 0; i < QUEUE_DEPTH; i++)
				slot_kind_q[i] <= nx_kind[i];
			mode_q   <= nx_mode;
			level_q  <= nx_level;
			remain_q <= nx_remain;
			decay_q  <= nx_decay;
			lead_q   <= nx_lead;
			acc_q    <= nx_acc;
			pcount_q <= nx_pcount;
			period_q <= nx_period;
			pak_q    <= nx_pak;
			err_q    <= nx_err;
			if (load_rsp)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	// Slot payloads, captured tick and result beat
	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			slot_level_q[i] <= nx_slot_lvl[i];
			slot_dur_q[i]   <= nx_slot_dur[i];
			slot_decay_q[i] <= nx_slot_dec[i];
		end
		if (mod_start)
			tick_q <= head;
		if (load_rsp)
			rsp_q <= rsp_d;
	end

endmodule

// ===== rtl/hmpe_checker.sv =====
// Port-level checks of the pattern engine's result stream, bound to the top level.
module hmpe_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input hmpe_pkg::rsp_t rsp
);

	// Hold a stalled result beat
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result beat changed");

	// No start request without a command
	a_on_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.motor_cmd_valid |-> !rsp.motor_on)
		else $error("motor_on without motor command");

	// A command together with a probe only comes from cancel: a stop to a found pak
	a_cancel_stop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.motor_cmd_valid && rsp.probe_issued |->
			rsp.pak_present && !rsp.motor_on)
		else $error("probe with command is not a stop to a present pak");

endmodule

bind haptic_motor_pattern_engine hmpe_checker u_hmpe_checker (.*);
